// ===== sv/wft_pkg.sv =====
// shared types, constants and helpers for the windowed failure throttle
// no dependencies
package wft_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] MAX_FAILURES_RESET = 16'd5;
   localparam logic [19:0] WINDOW_RESET = 20'd300;

   // request function codes
   localparam logic [1:0] FUNC_CHECK = 2'd0;
   localparam logic [1:0] FUNC_FAILED = 2'd1;
   localparam logic [1:0] FUNC_SUCCEEDED = 2'd2;
   localparam logic [1:0] FUNC_CLEAR = 2'd3;

   // register indexes
   localparam logic [1:0] REG_MAX_FAILURES = 2'd0;
   localparam logic [1:0] REG_WINDOW = 2'd1;

   // counted_as codes
   localparam logic [1:0] KEY_NONE = 2'd0;
   localparam logic [1:0] KEY_ACCOUNT = 2'd1;
   localparam logic [1:0] KEY_PAIR = 2'd2;

   typedef enum logic [2:0] {
      OP_CHECK,
      OP_FAIL,
      OP_SUCCEED,
      OP_CLEAR,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type op;
      logic address_present;
      logic [31:0] account_id;
      logic [31:0] address_id;
      logic [31:0] now_seconds;
   } item_type;

   typedef struct packed {
      logic is_pair;
      logic [31:0] account;
      logic [31:0] address;
      logic [15:0] failures;
      logic [31:0] started;
      logic reported;
   } entry_type;

   function automatic logic [31:0] elapsed(input logic [31:0] now, input logic [31:0] started);
      return (now >= started) ? (now - started) : 32'd0;
   endfunction

endpackage

// ===== sv/windowed_failure_throttle_unit.sv =====
// top level of the windowed failure throttle: front queue plus table back end
// depends on wft_pkg, wft_front, wft_back
//
//   port group  dir  handshake           contents
//   req_        in   tvalid/tready       request: tuser func, tdata fields
//   rsp_        out  tvalid/tready       one response per request
//   csr_        in   we only             max_failures, window_seconds
//
// a request with one key takes one scan and one with an address takes two,
// each a one-entry-per-cycle walk of the 256-entry table memory
// clear and requests without an account skip the scan
// synchronous active-high reset empties the table at once through per-entry valid bits
// a two-deep request queue lets up to two requests be taken while a response waits
module windowed_failure_throttle_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // account_present, account_id, address_present, address_id, now_seconds
   input  logic [103:0] req_tdata,
   // func
   input  logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // allowed, first_this_window, retry_after, tracked_count
   output logic [31:0] rsp_tdata,
   // counted_as
   output logic [1:0] rsp_tuser,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [19:0] csr_wdata
);

   logic head_valid, head_pop;
   wft_pkg::item_type head_item;

   wft_front u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .head_valid(head_valid),
      .head_item(head_item),
      .head_pop(head_pop)
   );

   wft_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_item(head_item),
      .head_pop(head_pop),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   // a blocked request names a key and a nonzero wait
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[21:2] != '0 && rsp_tuser != wft_pkg::KEY_NONE))
      else $error("blocked response without key or retry time");

   // an allowed request carries no block details
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[21:2] == '0 && rsp_tuser == wft_pkg::KEY_NONE
         && !rsp_tdata[1]))
      else $error("allowed response with block details");

   // table occupancy never exceeds its size
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[30:22] <= 9'(wft_pkg::TABLE_ENTRIES)))
      else $error("tracked count beyond table size");

endmodule

// ===== sv/wft_front.sv =====
// front end: takes requests, classifies them and queues them for the back end
// depends on wft_pkg
module wft_front (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [103:0] req_tdata,
   input  logic [1:0] req_tuser,
   output logic head_valid,
   output wft_pkg::item_type head_item,
   input  logic head_pop
);

   localparam int PTR_W = $clog2(wft_pkg::QUEUE_DEPTH);

   wft_pkg::item_type slot_ff [wft_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0] fill_ff, fill_in;
   wft_pkg::item_type cls;
   logic push, pop;

   always_comb begin
      cls.address_present = req_tdata[33];
      cls.account_id = req_tdata[32:1];
      cls.address_id = req_tdata[65:34];
      cls.now_seconds = req_tdata[97:66];
      unique case (req_tuser)
         wft_pkg::FUNC_CLEAR: cls.op = wft_pkg::OP_CLEAR;
         wft_pkg::FUNC_CHECK: cls.op = req_tdata[0] ? wft_pkg::OP_CHECK : wft_pkg::OP_NOP;
         wft_pkg::FUNC_FAILED: cls.op = req_tdata[0] ? wft_pkg::OP_FAIL : wft_pkg::OP_NOP;
         default: cls.op = req_tdata[0] ? wft_pkg::OP_SUCCEED : wft_pkg::OP_NOP;
      endcase
   end

   assign req_tready = (fill_ff != (PTR_W+1)'(wft_pkg::QUEUE_DEPTH));
   assign push = req_tvalid && req_tready;
   assign head_valid = (fill_ff != '0);
   assign pop = head_pop && head_valid;
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== sv/wft_back.sv =====
// back end: scans the failure table per key, updates it and forms the response
// depends on wft_pkg
module wft_back (
   input  logic clock,
   input  logic reset,
   input  logic head_valid,
   input  wft_pkg::item_type head_item,
   output logic head_pop,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [19:0] csr_wdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic [1:0] rsp_tuser
);

   localparam int IDX_W = wft_pkg::IDX_W;
   localparam int CNT_W = wft_pkg::CNT_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_ACT = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   wft_pkg::entry_type table_mem [wft_pkg::TABLE_ENTRIES];
   wft_pkg::entry_type rd_data_ff;
   logic mem_we;
   logic [IDX_W-1:0] mem_wa;
   wft_pkg::entry_type mem_wd;

   logic [1:0] state_ff, state_in;
   wft_pkg::item_type item_ff, item_in;
   logic key_pair_ff, key_pair_in;
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic found_ff, found_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   wft_pkg::entry_type hit_ff, hit_in;
   logic free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic ev_found_ff, ev_found_in;
   logic [IDX_W-1:0] ev_idx_ff, ev_idx_in;
   logic [31:0] ev_started_ff, ev_started_in;
   logic [wft_pkg::TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic allowed_ff, allowed_in;
   logic first_ff, first_in;
   logic [19:0] retry_ff, retry_in;
   logic [1:0] counted_ff, counted_in;
   logic [15:0] max_ff, max_in;
   logic [19:0] win_ff, win_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [1:0] rsp_user_ff, rsp_user_in;

   logic match, cmp_valid, expired_c;
   logic [31:0] el_scan, el_hit;
   logic [19:0] left;
   logic [IDX_W-1:0] tgt;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   always_comb begin
      cmp_valid = valid_ff[cmp_idx_ff];
      match = cmp_valid && (rd_data_ff.is_pair == key_pair_ff)
         && (rd_data_ff.account == item_ff.account_id)
         && (!key_pair_ff || (rd_data_ff.address == item_ff.address_id));
      el_scan = wft_pkg::elapsed(item_ff.now_seconds, rd_data_ff.started);
      expired_c = cmp_valid && (el_scan >= {12'd0, win_ff});
      el_hit = wft_pkg::elapsed(item_ff.now_seconds, hit_ff.started);
      left = win_ff - el_hit[19:0];
      tgt = free_found_ff ? free_idx_ff : (ev_found_ff ? ev_idx_ff : '0);
   end

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      key_pair_in = key_pair_ff;
      scan_cnt_in = scan_cnt_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      found_in = found_ff;
      hit_idx_in = hit_idx_ff;
      hit_in = hit_ff;
      free_found_in = free_found_ff;
      free_idx_in = free_idx_ff;
      ev_found_in = ev_found_ff;
      ev_idx_in = ev_idx_ff;
      ev_started_in = ev_started_ff;
      valid_in = valid_ff;
      count_in = count_ff;
      allowed_in = allowed_ff;
      first_in = first_ff;
      retry_in = retry_ff;
      counted_in = counted_ff;
      max_in = max_ff;
      win_in = win_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      head_pop = 1'b0;
      mem_we = 1'b0;
      mem_wa = hit_idx_ff;
      mem_wd = hit_ff;

      if (csr_we) begin
         unique case (csr_index)
            wft_pkg::REG_MAX_FAILURES:
               max_in = (csr_wdata[15:0] == '0) ? 16'd1 : csr_wdata[15:0];
            wft_pkg::REG_WINDOW:
               win_in = (csr_wdata == '0) ? 20'd1 : csr_wdata;
            default: ;
         endcase
      end

      // per-entry compare, in the cycle after the read of that entry
      if (cmp_vld_ff) begin
         if (match && !found_ff) begin
            found_in = 1'b1;
            hit_idx_in = cmp_idx_ff;
            hit_in = rd_data_ff;
         end
         if (!cmp_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
         if (expired_c && (!ev_found_ff || rd_data_ff.started < ev_started_ff)) begin
            ev_found_in = 1'b1;
            ev_idx_in = cmp_idx_ff;
            ev_started_in = rd_data_ff.started;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               item_in = head_item;
               allowed_in = 1'b1;
               first_in = 1'b0;
               retry_in = '0;
               counted_in = wft_pkg::KEY_NONE;
               key_pair_in = 1'b0;
               scan_cnt_in = '0;
               found_in = 1'b0;
               free_found_in = 1'b0;
               ev_found_in = 1'b0;
               unique case (head_item.op)
                  wft_pkg::OP_CLEAR: begin
                     valid_in = '0;
                     count_in = '0;
                     state_in = S_RESP;
                  end
                  wft_pkg::OP_NOP: state_in = S_RESP;
                  default: state_in = S_SCAN;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_cnt_ff != CNT_W'(wft_pkg::TABLE_ENTRIES)) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_cnt_ff[IDX_W-1:0];
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end else begin
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            unique case (item_ff.op)
               wft_pkg::OP_CHECK: begin
                  if (found_ff) begin
                     if (el_hit >= {12'd0, win_ff}) begin
                        mem_we = 1'b1;
                        mem_wd.failures = '0;
                        mem_wd.reported = 1'b0;
                     end else if (hit_ff.failures >= max_ff) begin
                        allowed_in = 1'b0;
                        if (left > retry_ff) begin
                           retry_in = left;
                        end
                        if (!hit_ff.reported) begin
                           mem_we = 1'b1;
                           mem_wd.reported = 1'b1;
                           first_in = 1'b1;
                        end
                        if (counted_ff == wft_pkg::KEY_NONE) begin
                           counted_in = key_pair_ff ? wft_pkg::KEY_PAIR : wft_pkg::KEY_ACCOUNT;
                        end
                     end
                  end
               end
               wft_pkg::OP_FAIL: begin
                  mem_we = 1'b1;
                  if (found_ff) begin
                     if (el_hit >= {12'd0, win_ff}) begin
                        mem_wd.failures = 16'd1;
                        mem_wd.started = item_ff.now_seconds;
                        mem_wd.reported = 1'b0;
                     end else if (hit_ff.failures != 16'hFFFF) begin
                        mem_wd.failures = hit_ff.failures + 1'b1;
                     end
                  end else begin
                     // new key: lowest free slot, else the oldest expired one, else slot zero
                     mem_wa = tgt;
                     mem_wd.is_pair = key_pair_ff;
                     mem_wd.account = item_ff.account_id;
                     mem_wd.address = key_pair_ff ? item_ff.address_id : 32'd0;
                     mem_wd.failures = 16'd1;
                     mem_wd.started = item_ff.now_seconds;
                     mem_wd.reported = 1'b0;
                     valid_in[tgt] = 1'b1;
                     if (free_found_ff) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
               end
               default: begin
                  if (found_ff) begin
                     valid_in[hit_idx_ff] = 1'b0;
                     count_in = count_ff - 1'b1;
                  end
               end
            endcase
            if (!key_pair_ff && item_ff.address_present) begin
               key_pair_in = 1'b1;
               scan_cnt_in = '0;
               found_in = 1'b0;
               free_found_in = 1'b0;
               ev_found_in = 1'b0;
               state_in = S_SCAN;
            end else begin
               state_in = S_RESP;
            end
         end
         default: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {1'b0, count_ff, retry_ff, first_ff, allowed_ff};
               rsp_user_in = counted_ff;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= table_mem[scan_cnt_ff[IDX_W-1:0]];
      if (mem_we) begin
         table_mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      key_pair_ff <= key_pair_in;
      scan_cnt_ff <= scan_cnt_in;
      cmp_idx_ff <= cmp_idx_in;
      found_ff <= found_in;
      hit_idx_ff <= hit_idx_in;
      hit_ff <= hit_in;
      free_found_ff <= free_found_in;
      free_idx_ff <= free_idx_in;
      ev_found_ff <= ev_found_in;
      ev_idx_ff <= ev_idx_in;
      ev_started_ff <= ev_started_in;
      allowed_ff <= allowed_in;
      first_ff <= first_in;
      retry_ff <= retry_in;
      counted_ff <= counted_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (reset) begin
         state_ff <= S_IDLE;
         cmp_vld_ff <= 1'b0;
         valid_ff <= '0;
         count_ff <= '0;
         max_ff <= wft_pkg::MAX_FAILURES_RESET;
         win_ff <= wft_pkg::WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
         max_ff <= max_in;
         win_ff <= win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== dv/windowed_failure_throttle_unit_tb.sv =====
// testbench for windowed_failure_throttle_unit: random and directed requests,
// responses checked against an in-bench model of the failure table
// depends on wft_pkg and the rtl of windowed_failure_throttle_unit
module windowed_failure_throttle_unit_tb;

   // index past the last register, writes to it are dropped
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct {
      logic [1:0] func;
      logic account_present;
      logic [31:0] account_id;
      logic address_present;
      logic [31:0] address_id;
      logic [31:0] now_seconds;
   } request_type;

   typedef struct packed {
      logic allowed;
      logic first_this_window;
      logic [19:0] retry_after;
      logic [1:0] counted_as;
      logic [8:0] tracked_count;
   } verdict_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [103:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [31:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_we;
   logic [1:0] csr_index;
   logic [19:0] csr_wdata;

   windowed_failure_throttle_unit dut (.*);

   // model state
   logic tbl_valid [wft_pkg::TABLE_ENTRIES];
   logic tbl_pair [wft_pkg::TABLE_ENTRIES];
   logic [31:0] tbl_account [wft_pkg::TABLE_ENTRIES];
   logic [31:0] tbl_address [wft_pkg::TABLE_ENTRIES];
   logic [15:0] tbl_failures [wft_pkg::TABLE_ENTRIES];
   logic [31:0] tbl_started [wft_pkg::TABLE_ENTRIES];
   logic tbl_reported [wft_pkg::TABLE_ENTRIES];
   logic [31:0] limit_failures;
   logic [31:0] limit_window;

   request_type pending_requests[$];
   verdict_type expected_verdicts[$];
   int idle_req_pct, idle_rsp_pct;
   int rsp_holdoff;
   int mismatches, responses_seen, blocked_seen;
   logic [31:0] clock_now;
   logic [31:0] account_pool [8];
   logic [31:0] address_pool [4];

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #60000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [31:0] age_of(int i, logic [31:0] now);
      return now >= tbl_started[i] ? now - tbl_started[i] : 32'd0;
   endfunction

   function automatic int lookup_key(logic pair, logic [31:0] acc, logic [31:0] addr);
      for (int i = 0; i < wft_pkg::TABLE_ENTRIES; i++)
         if (tbl_valid[i] && tbl_pair[i] == pair && tbl_account[i] == acc &&
               (!pair || tbl_address[i] == addr))
            return i;
      return -1;
   endfunction

   function automatic int lowest_free();
      for (int i = 0; i < wft_pkg::TABLE_ENTRIES; i++)
         if (!tbl_valid[i]) return i;
      return -1;
   endfunction

   function automatic void count_failure(logic pair, logic [31:0] acc, logic [31:0] addr,
                                         logic [31:0] now);
      int i;
      int pick;
      i = lookup_key(pair, acc, addr);
      if (i < 0) begin
         i = lowest_free();
         if (i < 0) begin
            // table full: oldest expired entry goes, else entry zero
            pick = -1;
            for (int k = 0; k < wft_pkg::TABLE_ENTRIES; k++)
               if (tbl_valid[k] && age_of(k, now) >= limit_window &&
                     (pick < 0 || tbl_started[k] < tbl_started[pick]))
                  pick = k;
            if (pick < 0) pick = 0;
            tbl_valid[pick] = 0;
            i = lowest_free();
         end
         tbl_valid[i] = 1;
         tbl_pair[i] = pair;
         tbl_account[i] = acc;
         tbl_address[i] = pair ? addr : 32'd0;
         tbl_failures[i] = 0;
         tbl_started[i] = now;
         tbl_reported[i] = 0;
      end
      if (age_of(i, now) >= limit_window) begin
         tbl_failures[i] = 0;
         tbl_started[i] = now;
         tbl_reported[i] = 0;
      end
      if (tbl_failures[i] != 16'hffff) tbl_failures[i]++;
   endfunction

   function automatic logic entry_blocks(int i, logic [31:0] now, ref logic [19:0] retry,
                                         ref logic first);
      logic [31:0] el;
      logic [31:0] left;
      if (i < 0) return 0;
      el = age_of(i, now);
      if (el >= limit_window) begin
         tbl_failures[i] = 0;
         tbl_reported[i] = 0;
         return 0;
      end
      if (tbl_failures[i] < limit_failures) return 0;
      left = limit_window - el;
      if (left > retry) retry = left[19:0];
      if (!tbl_reported[i]) begin
         tbl_reported[i] = 1;
         first = 1;
      end
      return 1;
   endfunction

   function automatic verdict_type throttle_step(request_type r);
      verdict_type v;
      int n;
      int i;
      logic [19:0] retry;
      logic first;
      v = '{allowed: 1, first_this_window: 0, retry_after: 0,
            counted_as: wft_pkg::KEY_NONE, tracked_count: 0};
      retry = '0;
      first = 1'b0;
      if (r.func == wft_pkg::FUNC_CLEAR) begin
         foreach (tbl_valid[k]) tbl_valid[k] = 0;
      end else if (r.account_present) begin
         if (r.func == wft_pkg::FUNC_CHECK) begin
            if (entry_blocks(lookup_key(0, r.account_id, 0), r.now_seconds, retry, first)) begin
               v.allowed = 0;
               v.counted_as = wft_pkg::KEY_ACCOUNT;
            end
            if (r.address_present &&
                  entry_blocks(lookup_key(1, r.account_id, r.address_id), r.now_seconds,
                               retry, first)) begin
               v.allowed = 0;
               if (v.counted_as == wft_pkg::KEY_NONE) v.counted_as = wft_pkg::KEY_PAIR;
            end
            v.retry_after = retry;
            v.first_this_window = first;
         end else if (r.func == wft_pkg::FUNC_FAILED) begin
            count_failure(0, r.account_id, 0, r.now_seconds);
            if (r.address_present)
               count_failure(1, r.account_id, r.address_id, r.now_seconds);
         end else begin
            i = lookup_key(0, r.account_id, 0);
            if (i >= 0) tbl_valid[i] = 0;
            if (r.address_present) begin
               i = lookup_key(1, r.account_id, r.address_id);
               if (i >= 0) tbl_valid[i] = 0;
            end
         end
      end
      n = 0;
      foreach (tbl_valid[k]) n += tbl_valid[k];
      v.tracked_count = n[8:0];
      return v;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= idle_req_pct) begin
            request_type r;
            r = pending_requests.pop_front();
            expected_verdicts.push_back(throttle_step(r));
            req_tvalid <= 1;
            req_tuser <= r.func;
            req_tdata <= {6'd0, r.now_seconds, r.address_id, r.address_present, r.account_id,
                          r.account_present};
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // receiver readiness, with a long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (rsp_holdoff > 0) begin
         rsp_holdoff <= rsp_holdoff - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= $urandom_range(99) >= idle_rsp_pct;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         verdict_type e;
         verdict_type a;
         a.allowed = rsp_tdata[0];
         a.first_this_window = rsp_tdata[1];
         a.retry_after = rsp_tdata[21:2];
         a.tracked_count = rsp_tdata[30:22];
         a.counted_as = rsp_tuser;
         responses_seen++;
         if (expected_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h/%h", rsp_tdata, rsp_tuser);
         end else begin
            e = expected_verdicts.pop_front();
            if (!e.allowed) blocked_seen++;
            if (a !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"response %0d: exp allow %b first %b retry %0d key %0d cnt %0d,",
                            " got allow %b first %b retry %0d key %0d cnt %0d"},
                           responses_seen, e.allowed, e.first_this_window, e.retry_after,
                           e.counted_as, e.tracked_count,
                           a.allowed, a.first_this_window, a.retry_after, a.counted_as,
                           a.tracked_count);
            end
         end
      end
   end

   function automatic request_type make_req(logic [1:0] f, logic ap, logic [31:0] acc,
                                            logic bp, logic [31:0] addr, logic [31:0] now);
      request_type r;
      r = '{func: f, account_present: ap, account_id: acc, address_present: bp,
            address_id: addr, now_seconds: now};
      return r;
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [19:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      if (idx == wft_pkg::REG_MAX_FAILURES) limit_failures = val[15:0] == 0 ? 1 : val[15:0];
      else if (idx == wft_pkg::REG_WINDOW) limit_window = val == 0 ? 1 : val;
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || expected_verdicts.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // mostly well-formed random failures, checks, successes and clears on a small key pool
   task automatic random_phase(int count, int time_step);
      request_type r;
      logic [1:0] f;
      int k;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(99);
         f = k < 45 ? wft_pkg::FUNC_FAILED : k < 85 ? wft_pkg::FUNC_CHECK :
             k < 97 ? wft_pkg::FUNC_SUCCEEDED : wft_pkg::FUNC_CLEAR;
         clock_now += $urandom_range(time_step);
         if ($urandom_range(9) == 0)
            r = make_req(f, 1'($urandom_range(1)), $urandom, 1'($urandom_range(1)), $urandom,
                         clock_now);
         else
            r = make_req(f, $urandom_range(19) != 0, account_pool[$urandom_range(7)],
                         $urandom_range(3) != 0, address_pool[$urandom_range(3)], clock_now);
         pending_requests.push_back(r);
      end
   endtask

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = wft_pkg::FUNC_CHECK;
      rsp_tready = 0;
      csr_we = 0;
      csr_index = wft_pkg::REG_MAX_FAILURES;
      csr_wdata = 0;
      rsp_holdoff = 0;
      mismatches = 0;
      responses_seen = 0;
      blocked_seen = 0;
      idle_req_pct = 21;
      idle_rsp_pct = 45;
      foreach (tbl_valid[k]) tbl_valid[k] = 0;
      limit_failures = wft_pkg::MAX_FAILURES_RESET;
      limit_window = wft_pkg::WINDOW_RESET;
      foreach (account_pool[k]) account_pool[k] = $urandom;
      foreach (address_pool[k]) address_pool[k] = $urandom;
      account_pool[0] = 0;
      account_pool[1] = '1;
      address_pool[0] = 0;
      address_pool[1] = '1;
      repeat (7) @(posedge clock);
      reset <= 0;

      // directed: block on both keys, expiry, success, clear, no account
      write_reg(wft_pkg::REG_MAX_FAILURES, 0);
      write_reg(wft_pkg::REG_WINDOW, 0);
      write_reg(wft_pkg::REG_WINDOW, 100);
      write_reg(wft_pkg::REG_MAX_FAILURES, 2);
      write_reg(REG_UNUSED, 20'hfffff);
      for (int n = 0; n < 2; n++)
         pending_requests.push_back(make_req(wft_pkg::FUNC_FAILED, 1, '1, 1, '1, 32'd10));
      pending_requests.push_back(make_req(wft_pkg::FUNC_CHECK, 1, '1, 1, '1, 32'd50));
      pending_requests.push_back(make_req(wft_pkg::FUNC_CHECK, 1, '1, 1, '1, 32'd60));
      pending_requests.push_back(make_req(wft_pkg::FUNC_CHECK, 1, '1, 0, 0, 32'd5));
      pending_requests.push_back(make_req(wft_pkg::FUNC_FAILED, 1, '1, 1, 0, 32'd70));
      pending_requests.push_back(make_req(wft_pkg::FUNC_FAILED, 1, '1, 1, 0, 32'd71));
      pending_requests.push_back(make_req(wft_pkg::FUNC_CHECK, 0, '1, 1, 0, 32'd72));
      pending_requests.push_back(make_req(wft_pkg::FUNC_CHECK, 1, '1, 1, 0, 32'd109));
      pending_requests.push_back(make_req(wft_pkg::FUNC_CHECK, 1, '1, 1, 0, 32'd200));
      pending_requests.push_back(make_req(wft_pkg::FUNC_FAILED, 1, '1, 1, 0, 32'd200));
      pending_requests.push_back(make_req(wft_pkg::FUNC_SUCCEEDED, 1, '1, 1, 0, 32'd201));
      pending_requests.push_back(make_req(wft_pkg::FUNC_CHECK, 1, '1, 1, '1, 32'd201));
      pending_requests.push_back(make_req(wft_pkg::FUNC_FAILED, 0, 0, 0, 0, 32'hffff_ffff));
      pending_requests.push_back(make_req(wft_pkg::FUNC_CLEAR, 0, 0, 1, 0, 32'hffff_ffff));
      pending_requests.push_back(make_req(wft_pkg::FUNC_CHECK, 1, 0, 1, 0, 32'hffff_ffff));
      drain();

      // fill past capacity with distinct keys to force eviction
      write_reg(wft_pkg::REG_WINDOW, 20);
      clock_now = 1000;
      for (int n = 0; n < 140; n++) begin
         clock_now += $urandom_range(1);
         pending_requests.push_back(make_req(wft_pkg::FUNC_FAILED, 1, $urandom, 1, $urandom,
                                             clock_now));
      end
      // long receiver stall while requests keep coming
      rsp_holdoff = 3000;
      drain();

      write_reg(wft_pkg::REG_MAX_FAILURES, 3);
      write_reg(wft_pkg::REG_WINDOW, 1000);
      random_phase(300, 40);
      drain();

      idle_req_pct = 45;
      idle_rsp_pct = 21;
      write_reg(wft_pkg::REG_MAX_FAILURES, 1);
      write_reg(wft_pkg::REG_WINDOW, 1);
      random_phase(200, 2);
      drain();

      idle_req_pct = 0;
      idle_rsp_pct = 0;
      write_reg(wft_pkg::REG_MAX_FAILURES, 16'hffff);
      write_reg(wft_pkg::REG_WINDOW, 20'd1000000);
      random_phase(100, 5000);
      drain();
      write_reg(wft_pkg::REG_MAX_FAILURES, 4);
      write_reg(wft_pkg::REG_WINDOW, 500);
      random_phase(250, 60);
      drain();

      $display("covered %0d responses, %0d of them blocked, over six register settings",
               responses_seen, blocked_seen);
      $display("table filled past capacity and response side stalled for 3000 cycles");
      if (mismatches == 0 && expected_verdicts.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
